// File: rtl/core/srt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package srt_pkg;

    localparam int DEF_CAPACITY = 64;
    localparam int SCORE_W      = 20;
    localparam int NAME_W       = 64;
    localparam int STATUS_W     = 2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_DUP   = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_RD,
        S_SCAN_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_GET_RD,
        S_GET_DATA,
        S_RESULT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic    latch_item;
        logic    cur_zero;
        logic    cur_count;
        logic    cur_inc;
        logic    cur_dec;
        logic    pos_load;
        logic    rd_cur;
        logic    rd_prev;
        logic    rd_rank;
        logic    wr_shift;
        logic    wr_item;
        logic    cnt_inc;
        logic    rank_inc;
        logic    take_name;
        logic    set_status;
        status_t status_code;
        logic    out_load;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic item_is_get;
        logic rank_ok;
        logic cur_at_count;
        logic cur_at_pos;
        logic full;
        logic equal;
        logic ahead;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

// File: rtl/core/srt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module srt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire srt_pkg::dp_status_t dp_st,
    output srt_pkg::ctrl_cmd_t      cmd
);
    import srt_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SCAN_RD:
            begin
                // a get lands here only on the first cycle after accept
                if (dp_st.item_is_get)
                begin
                    state_next = dp_st.rank_ok ? S_GET_RD : S_RESULT;
                end
                else if (dp_st.cur_at_count)
                begin
                    state_next = dp_st.full ? S_RESULT : S_INSERT;
                end
                else
                begin
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP:
            begin
                if (dp_st.equal)
                begin
                    state_next = S_RESULT;
                end
                else if (dp_st.ahead)
                begin
                    state_next = dp_st.full ? S_RESULT : S_SHIFT_RD;
                end
                else
                begin
                    state_next = S_SCAN_RD;
                end
            end
            S_SHIFT_RD:
            begin
                state_next = dp_st.cur_at_pos ? S_INSERT : S_SHIFT_WR;
            end
            S_SHIFT_WR: state_next = S_SHIFT_RD;
            S_INSERT:   state_next = S_RESULT;
            S_GET_RD:   state_next = S_GET_DATA;
            S_GET_DATA: state_next = S_RESULT;
            S_RESULT:
            begin
                if (dp_st.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.status_code = ST_OK;
        in_stall        = (state_reg != S_IDLE);
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.latch_item = in_valid;
                cmd.cur_zero   = in_valid;
            end
            S_SCAN_RD:
            begin
                if (dp_st.item_is_get)
                begin
                    if (!dp_st.rank_ok)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_EMPTY;
                    end
                end
                else if (dp_st.cur_at_count)
                begin
                    if (dp_st.full)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_FULL;
                    end
                end
                else
                begin
                    cmd.rd_cur = 1'b1;
                end
            end
            S_SCAN_CMP:
            begin
                if (dp_st.equal)
                begin
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_DUP;
                end
                else if (dp_st.ahead)
                begin
                    if (dp_st.full)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_FULL;
                    end
                    else
                    begin
                        cmd.pos_load  = 1'b1;
                        cmd.cur_count = 1'b1;
                    end
                end
                else
                begin
                    cmd.cur_inc = 1'b1;
                end
            end
            S_SHIFT_RD:
            begin
                cmd.rd_prev = !dp_st.cur_at_pos;
            end
            S_SHIFT_WR:
            begin
                cmd.wr_shift = 1'b1;
                cmd.cur_dec  = 1'b1;
            end
            S_INSERT:
            begin
                cmd.wr_item = 1'b1;
                cmd.cnt_inc = 1'b1;
            end
            S_GET_RD:
            begin
                cmd.rd_rank = 1'b1;
            end
            S_GET_DATA:
            begin
                cmd.take_name = 1'b1;
                cmd.rank_inc  = 1'b1;
            end
            S_RESULT:
            begin
                cmd.out_load = dp_st.out_free;
            end
            default:
            begin
                cmd.status_code = ST_OK;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/srt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module srt_datapath #(
    parameter int CAPACITY = srt_pkg::DEF_CAPACITY
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         command,
    input  wire logic [srt_pkg::SCORE_W-1:0]  entry_score,
    input  wire logic [srt_pkg::NAME_W-1:0]   entry_name,
    input  wire srt_pkg::ctrl_cmd_t           cmd,
    output srt_pkg::dp_status_t               dp_st,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [srt_pkg::STATUS_W-1:0]      status,
    output logic [srt_pkg::NAME_W-1:0]        result_name
);
    import srt_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [SCORE_W-1:0] score_mem [CAPACITY];
    logic [NAME_W-1:0]  name_mem  [CAPACITY];

    logic               get_reg;
    logic [SCORE_W-1:0] item_score_reg;
    logic [NAME_W-1:0]  item_name_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   rank_reg;
    logic [CNT_W-1:0]   cur_reg;
    logic [CNT_W-1:0]   cur_next;
    logic [CNT_W-1:0]   pos_reg;
    logic [SCORE_W-1:0] rd_score_reg;
    logic [NAME_W-1:0]  rd_name_reg;
    status_t            pend_status_reg;
    logic [NAME_W-1:0]  pend_name_reg;
    logic               out_valid_reg;
    status_t            status_reg;
    logic [NAME_W-1:0]  result_reg;

    logic [CNT_W-1:0]   cur_prev;
    logic [IDX_W-1:0]   rd_addr;
    logic               rd_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               wr_en;
    logic [SCORE_W-1:0] wr_score;
    logic [NAME_W-1:0]  wr_name;

    assign cur_prev = cur_reg - CNT_W'(1);
    assign rd_en    = cmd.rd_cur | cmd.rd_prev | cmd.rd_rank;
    assign wr_en    = cmd.wr_shift | cmd.wr_item;
    assign wr_addr  = cur_reg[IDX_W-1:0];
    assign wr_score = cmd.wr_item ? item_score_reg : rd_score_reg;
    assign wr_name  = cmd.wr_item ? item_name_reg : rd_name_reg;

    always_comb
    begin
        priority if (cmd.rd_rank)
        begin
            rd_addr = rank_reg[IDX_W-1:0];
        end
        else if (cmd.rd_prev)
        begin
            rd_addr = cur_prev[IDX_W-1:0];
        end
        else
        begin
            rd_addr = cur_reg[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            score_mem[wr_addr] <= wr_score;
            name_mem[wr_addr]  <= wr_name;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_score_reg <= score_mem[rd_addr];
            rd_name_reg  <= name_mem[rd_addr];
        end
    end

    always_comb
    begin
        priority if (cmd.cur_zero)
        begin
            cur_next = '0;
        end
        else if (cmd.cur_count)
        begin
            cur_next = count_reg;
        end
        else if (cmd.cur_inc)
        begin
            cur_next = cur_reg + CNT_W'(1);
        end
        else if (cmd.cur_dec)
        begin
            cur_next = cur_prev;
        end
        else
        begin
            cur_next = cur_reg;
        end
    end

    // item latch and scan registers
    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        if (cmd.latch_item)
        begin
            get_reg        <= command;
            item_score_reg <= entry_score;
            item_name_reg  <= entry_name;
        end
        if (cmd.pos_load)
        begin
            pos_reg <= cur_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            pend_status_reg <= ST_OK;
            pend_name_reg   <= '0;
        end
        else
        begin
            if (cmd.set_status)
            begin
                pend_status_reg <= cmd.status_code;
            end
            if (cmd.take_name)
            begin
                pend_name_reg <= rd_name_reg;
            end
        end
        if (cmd.out_load)
        begin
            status_reg <= pend_status_reg;
            result_reg <= pend_name_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rank_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.rank_inc)
            begin
                rank_reg <= rank_reg + CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        dp_st.item_is_get  = get_reg;
        dp_st.rank_ok      = (rank_reg < count_reg);
        dp_st.cur_at_count = (cur_reg == count_reg);
        dp_st.cur_at_pos   = (cur_reg == pos_reg);
        dp_st.full         = (count_reg == CNT_W'(CAPACITY));
        dp_st.equal        = (rd_score_reg == item_score_reg)
                             && (rd_name_reg == item_name_reg);
        dp_st.ahead        = (item_score_reg > rd_score_reg)
                             || ((item_score_reg == rd_score_reg)
                                 && (item_name_reg < rd_name_reg));
        dp_st.out_free     = !out_valid_reg || !out_stall;
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign result_name = result_reg;

endmodule

`default_nettype wire

// File: rtl/core/sorted_rank_tracker.sv
`timescale 1ns / 1ps
`default_nettype none

// channel  signals                             handshake
// -------  ----------------------------------  --------------------------
// in       command, entry_score, entry_name     in_valid / in_stall
// out      status, result_name                  out_valid / out_stall
//
// One item at a time. A get whose rank is below the count passes the scan-read,
// get-read and get-data states before the result register loads. An add walks
// the table through the single memory read port, a read and a compare state per
// entry, then appends at the tail or scans to the insert point and shifts the
// tail down a slot per read and write state; a rejected add stops at the scan.
// Reset clears the entry count and the get rank; the table memory needs no
// clearing since only entries below the count are ever read.
// A stalled result holds in the output register and holds the sequencer; a
// new item is taken from the cycle its predecessor first shows in that register.

module sorted_rank_tracker #(
    parameter int CAPACITY = srt_pkg::DEF_CAPACITY
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         command,
    input  wire logic [srt_pkg::SCORE_W-1:0]  entry_score,
    input  wire logic [srt_pkg::NAME_W-1:0]   entry_name,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [srt_pkg::STATUS_W-1:0]      status,
    output logic [srt_pkg::NAME_W-1:0]        result_name
);
    import srt_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t dp_st;

    // sequencer: scan, shift, insert and get steps
    srt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .dp_st    (dp_st),
        .cmd      (cmd)
    );

    // table memory, counters, compare and output register
    srt_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .command     (command),
        .entry_score (entry_score),
        .entry_name  (entry_name),
        .cmd         (cmd),
        .dp_st       (dp_st),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .result_name (result_name)
    );

    // an accepted item blocks the input until it is done
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input taken again right after an accept");

    // only a successful get carries a name
    a_name_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (result_name != '0)) |-> (status == ST_OK))
        else $error("nonzero name with failing status");

    // a new result appears only while the sequencer is still busy
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result without an item in work");

endmodule

`default_nettype wire
